// ===== design/reflow_profile_setpoint_unit_defines.svh =====
// Assertion macros for the reflow setpoint unit design file.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef REFLOW_PROFILE_SETPOINT_UNIT_DEFINES_SVH
`define REFLOW_PROFILE_SETPOINT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPSU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rpsu_pkg.sv =====
// Types, constants and breakpoint tables for the reflow setpoint unit.
// No dependencies; used by rpsu_ram and reflow_profile_setpoint_unit.
package rpsu_pkg;

	localparam int ROW_W     = 2;
	localparam int TIME_W    = 9;
	localparam int TEMP_W    = 8;
	localparam int DIV_STEPS = 18;

	localparam logic [TIME_W-1:0] SECS_CLAMP     = 9'd500;
	localparam logic [TEMP_W-1:0] SETPOINT_FLOOR = 8'd50;
	localparam logic [TEMP_W-1:0] SETPOINT_CEIL  = 8'd250;

	localparam int TBL_ROWS = 3;
	localparam int TBL_COLS = 10;

	typedef struct packed {
		logic [TIME_W-1:0] bp_time;
		logic [TEMP_W-1:0] bp_temp;
	} rpsu_bp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD0,
		ST_WALK,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} rpsu_state_t;

	localparam logic [TIME_W-1:0] BP_TIME [TBL_ROWS][TBL_COLS] = '{
		'{9'd0, 9'd80, 9'd170, 9'd260, 9'd290, 9'd390, 9'd500, 9'd500, 9'd500, 9'd500},
		'{9'd0, 9'd70, 9'd160, 9'd250, 9'd280, 9'd360, 9'd500, 9'd500, 9'd500, 9'd500},
		'{9'd0, 9'd50, 9'd140, 9'd190, 9'd220, 9'd280, 9'd500, 9'd500, 9'd500, 9'd500}
	};

	localparam logic [TEMP_W-1:0] BP_TEMP [TBL_ROWS][TBL_COLS] = '{
		'{8'd50, 8'd150, 8'd180, 8'd250, 8'd250, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50},
		'{8'd50, 8'd120, 8'd150, 8'd220, 8'd220, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50},
		'{8'd50, 8'd100, 8'd130, 8'd170, 8'd170, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50}
	};

	localparam logic [TIME_W-1:0] COOL_TIME [TBL_ROWS] = '{9'd290, 9'd280, 9'd220};

	// Breakpoint lookup; rows and columns past the built-in data read as zero.
	function automatic rpsu_bp_t bp_lookup(input logic [ROW_W-1:0] row, input logic [4:0] col);
		rpsu_bp_t bp;
		bp = '0;
		if ((row < 2'(TBL_ROWS)) && (col < 5'(TBL_COLS))) begin
			bp.bp_time = BP_TIME[row][col[3:0]];
			bp.bp_temp = BP_TEMP[row][col[3:0]];
		end
		return bp;
	endfunction

	function automatic logic [TIME_W-1:0] cool_lookup(input logic [ROW_W-1:0] row);
		logic [TIME_W-1:0] t;
		t = '0;
		if (row < 2'(TBL_ROWS)) begin
			t = COOL_TIME[row];
		end
		return t;
	endfunction

endpackage

// ===== design/rpsu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on rpsu_pkg only through the project-wide import convention.
module rpsu_ram
	import rpsu_pkg::*;
#(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/reflow_profile_setpoint_unit.sv =====
// Reflow setpoint unit: breakpoint walk over a RAM copy of the profile tables,
// then a multiply and an 18-step restoring divide.
// Depends on rpsu_pkg, rpsu_ram and reflow_profile_setpoint_unit_defines.svh.
`include "reflow_profile_setpoint_unit_defines.svh"
// Flow: an accepted request goes through ST_LOAD0, ST_WALK (one breakpoint RAM read per cycle),
// ST_MUL, ST_DIV and ST_FIN before output tvalid; a new request is taken only back in ST_IDLE.
// Reset: profile 0; after reset a fill pass copies the tables into all
// 4 * 2**clog2(NUM_POINTS) RAM entries (64 by default) with s_axis_tready low.
module reflow_profile_setpoint_unit
	import rpsu_pkg::*;
#(
	parameter int NUM_POINTS   = 10,
	parameter int NUM_PROFILES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,       // [1:0] profile_select
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] elapsed_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [7:0] setpoint_celsius, [16:8] cooldown_start
);

	localparam int CW    = $clog2(NUM_POINTS);
	localparam int AW    = ROW_W + CW;
	localparam int DEPTH = 1 << AW;
	localparam int BP_W  = TIME_W + TEMP_W;
	localparam logic [CW-1:0] LAST_COL = CW'(NUM_POINTS - 1);
	localparam logic [4:0]    LAST_CNT = 5'(DIV_STEPS - 1);
	localparam logic signed [19:0] V_MIN = $signed({12'd0, SETPOINT_FLOOR});
	localparam logic signed [19:0] V_MAX = $signed({12'd0, SETPOINT_CEIL});

	rpsu_state_t state_q, state_d;

	logic [ROW_W-1:0]  profile_select_q;
	logic              fill_active_q;
	logic [AW-1:0]     fill_addr_q;
	logic              out_valid_q;
	logic [TEMP_W-1:0] out_sp_q;
	logic [TIME_W-1:0] out_cool_q;

	logic [TIME_W-1:0] t_q;
	logic [CW-1:0]     k_q;
	rpsu_bp_t          prev_q, cur_q;
	logic              neg_q, zero_span_q;
	logic [17:0]       quo_q;
	logic [9:0]        rem_q;
	logic [8:0]        div_q;
	logic [4:0]        div_cnt_q;

	rpsu_bp_t          rd_bp, fill_bp;
	logic [BP_W-1:0]   rdata;
	logic              re;
	logic [CW-1:0]     raddr_col;
	logic              advance, s_acc, out_load;

	logic signed [9:0]  dt, span;
	logic signed [8:0]  dv;
	logic signed [18:0] prod, prod_mag;
	logic signed [9:0]  span_mag;
	logic [9:0]         trial;
	logic               q_bit;
	logic signed [18:0] q_signed;
	logic signed [19:0] v_sum;
	logic [TEMP_W-1:0]  v_clamped;

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_cool_q, out_sp_q};
	assign rd_bp         = rpsu_bp_t'(rdata);
	assign fill_bp       = bp_lookup(fill_addr_q[AW-1:CW], 5'(fill_addr_q[CW-1:0]));
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign advance       = (k_q != LAST_COL) && (t_q > rd_bp.bp_time);
	assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	rpsu_ram #(
		.WIDTH(BP_W),
		.DEPTH(DEPTH)
	) u_bp_ram (
		.clk  (clk),
		.we   (fill_active_q),
		.waddr(fill_addr_q),
		.wdata(fill_bp),
		.re   (re),
		.raddr({profile_select_q, raddr_col}),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		re            = 1'b0;
		raddr_col     = '0;
		s_axis_tready = (state_q == ST_IDLE) && !fill_active_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					re      = 1'b1;
					state_d = ST_LOAD0;
				end
			end
			ST_LOAD0: begin
				re        = 1'b1;
				raddr_col = CW'(1);
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (advance) begin
					re        = 1'b1;
					raddr_col = k_q + CW'(1);
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == LAST_CNT) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: profile, fill sweep, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_select_q <= '0;
			fill_active_q    <= 1'b1;
			fill_addr_q      <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			// drop writes that name a profile that does not exist
			if (cfg_valid && ({3'd0, cfg_data} < 5'(NUM_PROFILES))) begin
				profile_select_q <= cfg_data;
			end
			if (fill_active_q) begin
				fill_addr_q <= fill_addr_q + AW'(1);
				if (fill_addr_q == {AW{1'b1}}) begin
					fill_active_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		dt       = $signed({1'b0, t_q}) - $signed({1'b0, prev_q.bp_time});
		span     = $signed({1'b0, cur_q.bp_time}) - $signed({1'b0, prev_q.bp_time});
		dv       = $signed({1'b0, cur_q.bp_temp}) - $signed({1'b0, prev_q.bp_temp});
		prod     = 19'(dt * dv);
		prod_mag = prod[18] ? -prod : prod;
		span_mag = span[9] ? -span : span;
		trial    = {rem_q[8:0], quo_q[17]};
		q_bit    = (trial >= {1'b0, div_q});
		q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		v_sum    = zero_span_q ? $signed({12'd0, prev_q.bp_temp})
		                       : 20'(q_signed) + $signed({12'd0, prev_q.bp_temp});
		if (v_sum < V_MIN) begin
			v_clamped = SETPOINT_FLOOR;
		end else if (v_sum > V_MAX) begin
			v_clamped = SETPOINT_CEIL;
		end else begin
			v_clamped = v_sum[7:0];
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					t_q <= (s_axis_tdata > 16'(SECS_CLAMP)) ? SECS_CLAMP : s_axis_tdata[8:0];
				end
			end
			ST_LOAD0: begin
				prev_q <= rd_bp;
				k_q    <= CW'(1);
			end
			ST_WALK: begin
				if (advance) begin
					prev_q <= rd_bp;
					k_q    <= k_q + CW'(1);
				end else begin
					cur_q <= rd_bp;
				end
			end
			ST_MUL: begin
				neg_q       <= prod[18] ^ span[9];
				zero_span_q <= (span == 10'sd0);
				quo_q       <= prod_mag[17:0];
				div_q       <= span_mag[8:0];
				rem_q       <= '0;
				div_cnt_q   <= '0;
			end
			ST_DIV: begin
				rem_q     <= q_bit ? (trial - {1'b0, div_q}) : trial;
				quo_q     <= {quo_q[16:0], q_bit};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_sp_q   <= v_clamped;
			out_cool_q <= cool_lookup(profile_select_q);
		end
	end

	`RPSU_ASSERT_IMPL(a_no_accept_in_fill, fill_active_q, !s_axis_tready,
		"input accepted during table fill")
	`RPSU_ASSERT_NEXT(a_accept_starts_walk, s_acc, state_q == ST_LOAD0,
		"accepted request did not start the walk")
	`RPSU_ASSERT_IMPL(a_walk_index, state_q == ST_WALK,
		(k_q >= CW'(1)) && (k_q <= LAST_COL), "walk index out of range")
	`RPSU_ASSERT_IMPL(a_div_count, state_q == ST_DIV, div_cnt_q <= LAST_CNT,
		"divider ran past its step count")
	`RPSU_ASSERT_IMPL(a_setpoint_range, m_axis_tvalid,
		(m_axis_tdata[7:0] >= SETPOINT_FLOOR) && (m_axis_tdata[7:0] <= SETPOINT_CEIL),
		"setpoint outside clamp range")

endmodule

// ===== verif/testbench.sv =====
// Stream testbench for reflow_profile_setpoint_unit: directed and random elapsed times
// under every profile setting, checked against a local piecewise-linear setpoint model.
// Depends on rpsu_pkg (temperature limits) and the design files under design/.
`timescale 1ns / 100ps
module testbench;
	import rpsu_pkg::*;

	localparam int POINTS     = 10;
	localparam int PROFILES   = 3;
	localparam int SECS_CAP   = 500;
	localparam int ITEM_GOAL  = 1900;
	localparam int SETTLE     = 64;
	localparam int CYCLE_CAP  = 1000000;

	localparam int PROF_TIME [PROFILES][POINTS] = '{
		'{0, 80, 170, 260, 290, 390, 500, 500, 500, 500},
		'{0, 70, 160, 250, 280, 360, 500, 500, 500, 500},
		'{0, 50, 140, 190, 220, 280, 500, 500, 500, 500}
	};
	localparam int PROF_TEMP [PROFILES][POINTS] = '{
		'{50, 150, 180, 250, 250, 50, 50, 50, 50, 50},
		'{50, 120, 150, 220, 220, 50, 50, 50, 50, 50},
		'{50, 100, 130, 170, 170, 50, 50, 50, 50, 50}
	};
	localparam int PROF_COOL [PROFILES] = '{290, 280, 220};

	typedef enum bit {REQ_SECONDS, REQ_PROFILE} req_kind_t;

	typedef struct {
		req_kind_t   kind;
		logic [15:0] value;
		int          gap;
	} oven_req_t;

	typedef struct {
		logic [TEMP_W-1:0] setpoint;
		logic [TIME_W-1:0] cooldown;
	} setpoint_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	oven_req_t     req_q[$];
	setpoint_exp_t setpoint_exp_q[$];
	int            n_items = 0;
	int            n_sent = 0;
	int            n_recv = 0;
	int            n_errors = 0;
	int            cycle_cnt = 0;
	int            profile_sel = 0;

	reflow_profile_setpoint_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Interpolate between the breakpoints around the clamped time, then clamp the temperature.
	function automatic logic [TEMP_W-1:0] interp_setpoint(input int row, input logic [15:0] secs);
		int t, k, t0, t1, v0, v1, span, v;
		t = (secs > SECS_CAP) ? SECS_CAP : int'(secs);
		k = 1;
		while (k < POINTS - 1 && t > PROF_TIME[row][k])
			k++;
		t0 = PROF_TIME[row][k-1];
		t1 = PROF_TIME[row][k];
		v0 = PROF_TEMP[row][k-1];
		v1 = PROF_TEMP[row][k];
		span = t1 - t0;
		if (span == 0)
			v = v0;
		else
			v = (t - t0) * (v1 - v0) / span + v0;
		if (v < int'(SETPOINT_FLOOR)) v = SETPOINT_FLOOR;
		if (v > int'(SETPOINT_CEIL)) v = SETPOINT_CEIL;
		return TEMP_W'(v);
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic add_seconds(input logic [15:0] secs, input bit burst);
		oven_req_t r;
		r.kind = REQ_SECONDS;
		r.value = secs;
		r.gap = draw_gap(burst);
		req_q.push_back(r);
		n_items++;
	endtask

	task automatic add_profile(input logic [1:0] prof, input bit burst);
		oven_req_t r;
		r.kind = REQ_PROFILE;
		r.value = 16'(prof);
		r.gap = draw_gap(burst);
		req_q.push_back(r);
	endtask

	// Mostly times inside the profile, a share within two seconds of breakpoints, some past the clamp, the rest anywhere.
	function automatic logic [15:0] draw_seconds();
		int pick, v;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			v = $urandom_range(0, SECS_CAP);
		end else if (pick < 75) begin
			v = PROF_TIME[$urandom_range(0, PROFILES-1)][$urandom_range(0, POINTS-1)];
			v = v + $urandom_range(0, 4) - 2;
			if (v < 0) v = 0;
		end else if (pick < 85) begin
			v = $urandom_range(SECS_CAP + 1, 65535);
		end else begin
			v = $urandom_range(0, 65535);
		end
		return 16'(v);
	endfunction

	// Driver: profile writes wait until every issued request has its result back.
	always @(posedge clk) begin : driver
		bit busy, nxt_sv, nxt_cv;
		setpoint_exp_t e;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			busy = s_axis_tvalid || cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				e.setpoint = interp_setpoint(profile_sel, s_axis_tdata);
				e.cooldown = TIME_W'(PROF_COOL[profile_sel]);
				setpoint_exp_q.push_back(e);
				n_sent <= n_sent + 1;
				busy = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				// drop out-of-range profile numbers
				if (int'(cfg_data) < PROFILES)
					profile_sel = cfg_data;
				busy = 1'b0;
			end
			nxt_sv = busy && s_axis_tvalid;
			nxt_cv = busy && cfg_valid;
			if (!busy && req_q.size() > 0) begin
				if (req_q[0].gap > 0) begin
					req_q[0].gap = req_q[0].gap - 1;
				end else if (req_q[0].kind == REQ_SECONDS) begin
					s_axis_tdata <= req_q[0].value;
					nxt_sv = 1'b1;
					void'(req_q.pop_front());
				end else if (setpoint_exp_q.size() == n_recv) begin
					cfg_data <= req_q[0].value[1:0];
					nxt_cv = 1'b1;
					void'(req_q.pop_front());
				end
			end
			s_axis_tvalid <= nxt_sv;
			cfg_valid <= nxt_cv;
		end
	end

	// Monitor: stall the result side at random, except in quiet windows.
	always @(posedge clk) begin : monitor
		int rx_wait;
		bit quiet;
		setpoint_exp_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (n_recv >= n_sent) begin
					$error("unexpected result: tdata %h", m_axis_tdata);
					n_errors++;
				end else begin
					e = setpoint_exp_q[n_recv];
					if (m_axis_tdata[7:0] !== e.setpoint) begin
						$error("setpoint_celsius: expected %0d, got %0d",
							e.setpoint, m_axis_tdata[7:0]);
						n_errors++;
					end
					if (m_axis_tdata[16:8] !== e.cooldown) begin
						$error("cooldown_start: expected %0d, got %0d",
							e.cooldown, m_axis_tdata[16:8]);
						n_errors++;
					end
					if (m_axis_tdata[23:17] !== 7'd0) begin
						$error("tdata padding: expected 0, got %h", m_axis_tdata[23:17]);
						n_errors++;
					end
					n_recv <= n_recv + 1;
				end
				quiet = ((cycle_cnt / 5000) % 4) == 1;
				rx_wait = quiet ? 0 : $urandom_range(0, 10);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_CAP);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] edge_secs [18];
		bit burst;
		int n;
		edge_secs = '{16'd0, 16'd1, 16'd79, 16'd80, 16'd81, 16'd169, 16'd170, 16'd290,
			16'd291, 16'd389, 16'd390, 16'd499, 16'd500, 16'd501, 16'hFFFF, 16'h8000,
			16'h5555, 16'hAAAA};
		// profile 0 straight out of reset
		foreach (edge_secs[i])
			add_seconds(edge_secs[i], 1'b0);
		add_profile(2'd2, 1'b0);
		add_seconds(16'd50, 1'b0);
		add_seconds(16'd220, 1'b0);
		add_seconds(16'd281, 1'b0);
		// profile 3 does not exist: profile 2 stays selected
		add_profile(2'd3, 1'b0);
		add_seconds(16'd140, 1'b0);
		add_seconds(16'hFFFF, 1'b0);
		add_profile(2'd1, 1'b0);
		add_seconds(16'd160, 1'b0);
		add_seconds(16'd359, 1'b0);
		while (n_items < ITEM_GOAL) begin
			burst = ($urandom_range(0, 3) == 0);
			add_profile(2'($urandom_range(0, 3)), burst);
			n = $urandom_range(40, 150);
			for (int i = 0; i < n; i++)
				add_seconds(draw_seconds(), burst);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (n_sent == n_items && n_recv == n_sent);
		repeat (SETTLE) @(posedge clk);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
